>>> sv/lpvp_pkg.sv
// ----------------------------------------------------------------------------
// lpvp_pkg
// Shared types, codes and helpers of the looping PCM voice player.
// ----------------------------------------------------------------------------
`default_nettype none

package lpvp_pkg;

	// width of the running phase accumulator (16-bit phase plus 16-bit pitch)
	localparam int FR_W = 17;

	// item modes
	localparam logic [2:0] MODE_TICK = 3'd0;
	localparam logic [2:0] MODE_WR_A = 3'd1;
	localparam logic [2:0] MODE_WR_B = 3'd2;
	localparam logic [2:0] MODE_RD_A = 3'd3;
	localparam logic [2:0] MODE_RD_B = 3'd4;
	localparam logic [2:0] MODE_LOAD = 3'd5;

	// register words within a bank
	localparam logic [1:0] OFF_STATUS = 2'd2;
	localparam logic [1:0] OFF_CMD    = 2'd3;

	// bank A command codes
	localparam logic [7:0] CMD_A_PLAY   = 8'h40;
	localparam logic [7:0] CMD_A_LOOP   = 8'h41;
	localparam logic [7:0] CMD_A_PITCH  = 8'h42;
	localparam logic [7:0] CMD_A_GETPOS = 8'h80;

	// bank B command codes
	localparam logic [7:0] CMD_B_END     = 8'h40;
	localparam logic [7:0] CMD_B_LOOPEND = 8'h41;
	localparam logic [7:0] CMD_B_SETF    = 8'h42;
	localparam logic [7:0] CMD_B_CLRF    = 8'h43;
	localparam logic [7:0] CMD_B_TRACE   = 8'h44;
	localparam logic [7:0] CMD_B_ACK     = 8'h46;
	localparam logic [7:0] CMD_B_GETF    = 8'h82;

	// voice flag bit positions
	localparam int F_PLAY    = 0;
	localparam int F_OUTPUT  = 1;
	localparam int F_LOOP    = 2;
	localparam int F_INT     = 3;
	localparam int F_REVERSE = 4;

	// per-voice state record held in the voice memory
	typedef struct packed {
		logic [15:0] flags;
		logic [31:0] play;
		logic [15:0] phase;
		logic [31:0] end_addr;
		logic [31:0] loop_start;
		logic [31:0] loop_end;
		logic [7:0]  loop_frac;
		logic        trace;
		logic [15:0] pitch;
		logic [15:0] cur;
		logic [15:0] prev;
	} voice_rec_t;

	// byte-lane merge of a bus write
	function automatic logic [15:0] merge16(input logic [15:0] old, input logic [15:0] data,
			input logic [1:0] be);
		logic [15:0] m;
		m = {{8{be[1]}}, {8{be[0]}}};
		return (old & ~m) | (data & m);
	endfunction

endpackage

`default_nettype wire

>>> sv/lpvp_req_if.sv
// ----------------------------------------------------------------------------
// lpvp_req_if
// Input item channel: bus access, memory load or audio tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpvp_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [1:0]  reg_offset;
	logic [15:0] write_data;
	logic [1:0]  byte_enable;
	logic [15:0] mem_address;
	logic signed [15:0] mem_sample;

	modport source(output valid, mode, reg_offset, write_data, byte_enable, mem_address,
		mem_sample, input ready);
	modport sink(input valid, mode, reg_offset, write_data, byte_enable, mem_address,
		mem_sample, output ready);
endinterface

`default_nettype wire

>>> sv/lpvp_rsp_if.sv
// ----------------------------------------------------------------------------
// lpvp_rsp_if
// Result item channel: voice outputs, read data and IRQ level.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpvp_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] voice_out_0;
	logic signed [15:0] voice_out_1;
	logic signed [15:0] voice_out_2;
	logic signed [15:0] voice_out_3;
	logic signed [15:0] voice_out_4;
	logic signed [15:0] voice_out_5;
	logic signed [15:0] voice_out_6;
	logic signed [15:0] voice_out_7;
	logic [15:0] read_data;
	logic        irq_out;

	modport source(output valid, voice_out_0, voice_out_1, voice_out_2, voice_out_3,
		voice_out_4, voice_out_5, voice_out_6, voice_out_7, read_data, irq_out,
		input ready);
	modport sink(input valid, voice_out_0, voice_out_1, voice_out_2, voice_out_3,
		voice_out_4, voice_out_5, voice_out_6, voice_out_7, read_data, irq_out,
		output ready);
endinterface

`default_nettype wire

>>> sv/lpvp_sample_ram.sv
// ----------------------------------------------------------------------------
// lpvp_sample_ram
// Sample word memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpvp_sample_ram #(
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [15:0]       wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [15:0]       rdata
);

	logic [15:0] mem [2**ADDR_W];
	logic [15:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> sv/lpvp_voice_ram.sv
// ----------------------------------------------------------------------------
// lpvp_voice_ram
// Per-voice state memory; entries not yet written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lpvp_voice_ram import lpvp_pkg::*; #(
	parameter int DEPTH = 8,
	parameter int IDX_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [IDX_W-1:0] widx,
	input  voice_rec_t       wdata,
	input  logic [IDX_W-1:0] ridx,
	output voice_rec_t       rdata
);

	voice_rec_t       mem [DEPTH];
	voice_rec_t       rdata_q;
	logic [DEPTH-1:0] valid_q;

	// mark written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[widx] <= 1'b1;
		end
	end

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[widx] <= wdata;
		end
		rdata_q <= valid_q[ridx] ? mem[ridx] : '0;
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> sv/lpvp_interp.sv
// ----------------------------------------------------------------------------
// lpvp_interp
// Recompute a voice output from its written-back state, in eighths.
// ----------------------------------------------------------------------------
`default_nettype none

module lpvp_interp import lpvp_pkg::*; #(
	parameter int VOICE_COUNT = 8,
	parameter int FRAC_BITS   = 15,
	parameter int VIDX_W      = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd_en,
	input  logic [VIDX_W-1:0] upd_idx,
	input  voice_rec_t        upd_rec,
	output logic [7:0][15:0]  voice_out
);

	logic                         en_s1;
	logic [VIDX_W-1:0]            idx_s1;
	voice_rec_t                   rec_s1;
	logic [VOICE_COUNT-1:0][15:0] out_q;

	logic signed [19:0] prev_w;
	logic signed [19:0] diff_w;
	logic signed [19:0] frac_w;
	logic signed [19:0] prod_w;
	logic signed [19:0] quot_w;
	logic signed [19:0] res_w;

	// capture the written-back record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= upd_en;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= upd_idx;
		rec_s1 <= upd_rec;
	end

	// prev + (cur - prev) * f / 8, truncating toward zero
	always_comb begin
		prev_w = 20'(signed'(rec_s1.prev));
		diff_w = 20'(signed'(rec_s1.cur)) - prev_w;
		frac_w = 20'(signed'({1'b0, rec_s1.phase[FRAC_BITS-1 -: 3]}));
		prod_w = diff_w * frac_w;
		quot_w = (prod_w + (prod_w[19] ? 20'sd7 : 20'sd0)) >>> 3;
		res_w  = prev_w + quot_w;
	end

	// hold the output of each voice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (en_s1) begin
			out_q[idx_s1] <= rec_s1.flags[F_OUTPUT] ? res_w[15:0] : 16'd0;
		end
	end

	// voices beyond the configured count stay silent
	for (genvar i = 0; i < 8; i++) begin : g_out
		if (i < VOICE_COUNT) begin : g_live
			assign voice_out[i] = out_q[i];
		end else begin : g_mute
			assign voice_out[i] = 16'd0;
		end
	end

endmodule

`default_nettype wire

>>> sv/looping_pcm_voice_player_core.sv
// ----------------------------------------------------------------------------
// looping_pcm_voice_player_core
// Eight-voice looping PCM sample player with two register banks.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    mode, reg_offset, write_data, byte_enable,
//                               mem_address, mem_sample
//  rsp      out  valid/ready    voice_out_0..7, read_data, irq_out
//
//  Register reads, writes and memory loads go straight to the result state;
//  a command first decodes, then walks each voice through read, execute and
//  write-back, while a status acknowledge goes from decode to the result.
//  A tick walks each voice through read, execute and write-back; a voice that
//  takes a sample also passes the sample and iterate states, and the loop state
//  after each forward step of a looping voice; a drain state ends both walks.
//  Reset clears banks, status and voice state (voice memory reads as zero).
//  A new item is taken while the previous result waits on rsp; the sequencer
//  stalls in its result state only while that result is still not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module looping_pcm_voice_player_core import lpvp_pkg::*; #(
	parameter int VOICE_COUNT      = 8,
	parameter int FRAC_BITS        = 15,
	parameter int SAMPLE_ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	lpvp_req_if.sink    req,
	lpvp_rsp_if.source  rsp
);

	localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int SHIFT  = FRAC_BITS - 8;
	localparam logic [FR_W-1:0] ONE = FR_W'(1) << FRAC_BITS;
	localparam logic [VIDX_W-1:0] LAST = VIDX_W'(VOICE_COUNT - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CMD  = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_EXEC = 4'd3;
	localparam logic [3:0] S_SAMP = 4'd4;
	localparam logic [3:0] S_ITER = 4'd5;
	localparam logic [3:0] S_LOOP = 4'd6;
	localparam logic [3:0] S_WB   = 4'd7;
	localparam logic [3:0] S_DR   = 4'd8;
	localparam logic [3:0] S_RESP = 4'd9;

	logic [3:0]        state_q;
	logic [VIDX_W-1:0] vidx_q;
	logic              op_tick_q;
	logic              bank_b_q;
	logic [2:0][15:0]  pa_q;
	logic [1:0][15:0]  pb_q;
	logic [15:0]       cmd_a_q;
	logic [15:0]       cmd_b_q;
	logic [7:0]        status_q;
	logic              irq_q;
	voice_rec_t        rec_q;
	logic [FR_W-1:0]   fr_q;
	logic [31:0]       delta_q;
	logic              looped_q;
	logic [15:0]       rd_q;
	logic              out_valid_q;
	logic [7:0][15:0]  out_voice_q;
	logic [15:0]       out_rd_q;
	logic              out_irq_q;

	logic              accept;
	voice_rec_t        vr_rdata;
	voice_rec_t        vr_wdata;
	logic              vr_we;
	logic [15:0]       sr_rdata;
	logic              sr_we;
	logic [7:0][15:0]  voice_now;
	logic [7:0]        cmd_code;
	logic [7:0]        cmd_mask;
	logic              sel;
	logic [FR_W-1:0]   fr_sum;
	logic [FR_W-1:0]   lsf_ext;
	logic [7:0]        ack_status;
	logic [3:0]        idle_next;
	logic [15:0]       idle_rd;
	voice_rec_t        exec_rec;
	logic [FR_W-1:0]   exec_fr;
	logic              exec_samp;
	logic              rsp_load;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid & req.ready;
	assign rsp_load  = (state_q == S_RESP) && (!out_valid_q || rsp.ready);

	// decode the pending command and voice operands
	always_comb begin
		cmd_code   = bank_b_q ? cmd_b_q[15:8] : cmd_a_q[15:8];
		cmd_mask   = bank_b_q ? cmd_b_q[7:0] : cmd_a_q[7:0];
		sel        = cmd_mask[vidx_q];
		fr_sum     = FR_W'(vr_rdata.phase) + FR_W'(vr_rdata.pitch);
		lsf_ext    = FR_W'(rec_q.loop_frac) << SHIFT;
		ack_status = status_q & pb_q[0][7:0];
		vr_wdata       = rec_q;
		vr_wdata.phase = fr_q[15:0];

		// next state and read value of an accepted item
		idle_next = S_RESP;
		idle_rd   = '0;
		case (req.mode)
			MODE_TICK: begin
				idle_next = S_RD;
			end
			MODE_WR_A: begin
				if (req.reg_offset == OFF_CMD && req.byte_enable[1]) begin
					idle_next = S_CMD;
				end
			end
			MODE_WR_B: begin
				if (req.reg_offset == OFF_CMD && req.byte_enable[1]) begin
					idle_next = S_CMD;
				end
			end
			MODE_RD_A: begin
				if (req.reg_offset == OFF_CMD) begin
					idle_rd = cmd_a_q;
				end else begin
					idle_rd = pa_q[req.reg_offset];
				end
			end
			MODE_RD_B: begin
				if (req.reg_offset == OFF_CMD) begin
					idle_rd = cmd_b_q;
				end else if (req.reg_offset == OFF_STATUS) begin
					idle_rd = {8'd0, status_q};
				end else begin
					idle_rd = pb_q[req.reg_offset[0]];
				end
			end
			default: begin
			end
		endcase

		// modify the voice record just read
		exec_rec  = vr_rdata;
		exec_fr   = FR_W'(vr_rdata.phase);
		exec_samp = 1'b0;
		if (!op_tick_q) begin
			if (sel && !bank_b_q) begin
				case (cmd_code)
					CMD_A_PLAY: begin
						exec_rec.play = {pa_q[2], pa_q[1]};
						exec_rec.cur  = '0;
						exec_rec.prev = '0;
						exec_fr       = '0;
					end
					CMD_A_LOOP: begin
						exec_rec.loop_start = {pa_q[1], pa_q[0]};
						exec_rec.loop_frac  = pa_q[2][7:0];
					end
					CMD_A_PITCH: begin
						exec_rec.pitch = pa_q[0];
					end
					default: begin
					end
				endcase
			end else if (sel) begin
				case (cmd_code)
					CMD_B_END: begin
						exec_rec.end_addr = {pb_q[1], pb_q[0]};
					end
					CMD_B_LOOPEND: begin
						exec_rec.loop_end = {pb_q[1], pb_q[0]};
					end
					CMD_B_SETF: begin
						exec_rec.flags = vr_rdata.flags | pb_q[0];
					end
					CMD_B_CLRF: begin
						exec_rec.flags = vr_rdata.flags & ~pb_q[0];
					end
					CMD_B_TRACE: begin
						exec_rec.trace = pb_q[0][0];
					end
					default: begin
					end
				endcase
			end
		end else if (vr_rdata.flags[F_PLAY]) begin
			exec_fr = fr_sum;
			if (fr_sum >= ONE) begin
				// sample read is in flight at the play address
				exec_rec.prev = vr_rdata.cur;
				exec_samp     = 1'b1;
			end
		end
	end

	assign vr_we = (state_q == S_WB);
	assign sr_we = accept && (req.mode == MODE_LOAD);

	lpvp_voice_ram #(
		.DEPTH (VOICE_COUNT),
		.IDX_W (VIDX_W)
	) u_voice_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (vr_we),
		.widx   (vidx_q),
		.wdata  (vr_wdata),
		.ridx   (vidx_q),
		.rdata  (vr_rdata)
	);

	lpvp_sample_ram #(
		.ADDR_W (SAMPLE_ADDR_BITS)
	) u_sample_ram (
		.clk   (clk),
		.we    (sr_we),
		.waddr (SAMPLE_ADDR_BITS'(req.mem_address)),
		.wdata (req.mem_sample),
		.raddr (SAMPLE_ADDR_BITS'(vr_rdata.play)),
		.rdata (sr_rdata)
	);

	lpvp_interp #(
		.VOICE_COUNT (VOICE_COUNT),
		.FRAC_BITS   (FRAC_BITS),
		.VIDX_W      (VIDX_W)
	) u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_en    (vr_we),
		.upd_idx   (vidx_q),
		.upd_rec   (vr_wdata),
		.voice_out (voice_now)
	);

	// sequencer: decode items, walk voices through read, modify, write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vidx_q      <= '0;
			op_tick_q   <= 1'b0;
			bank_b_q    <= 1'b0;
			pa_q        <= '0;
			pb_q        <= '0;
			cmd_a_q     <= '0;
			cmd_b_q     <= '0;
			status_q    <= '0;
			irq_q       <= 1'b0;
			rec_q       <= '0;
			fr_q        <= '0;
			delta_q     <= '0;
			looped_q    <= 1'b0;
			rd_q        <= '0;
			out_valid_q <= 1'b0;
			out_voice_q <= '0;
			out_rd_q    <= '0;
			out_irq_q   <= 1'b0;
		end else begin
			// load a new result, or drop the current one once taken
			if (rsp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_q    <= idle_rd;
						vidx_q  <= '0;
						state_q <= idle_next;
						case (req.mode)
							MODE_TICK: begin
								op_tick_q <= 1'b1;
							end
							MODE_WR_A: begin
								if (req.reg_offset == OFF_CMD) begin
									cmd_a_q <= merge16(cmd_a_q, req.write_data,
										req.byte_enable);
									if (req.byte_enable[1]) begin
										op_tick_q <= 1'b0;
										bank_b_q  <= 1'b0;
									end
								end else begin
									pa_q[req.reg_offset] <= merge16(pa_q[req.reg_offset],
										req.write_data, req.byte_enable);
								end
							end
							MODE_WR_B: begin
								if (req.reg_offset == OFF_CMD) begin
									cmd_b_q <= merge16(cmd_b_q, req.write_data,
										req.byte_enable);
									if (req.byte_enable[1]) begin
										op_tick_q <= 1'b0;
										bank_b_q  <= 1'b1;
									end
								end else if (req.reg_offset != OFF_STATUS) begin
									pb_q[req.reg_offset[0]] <= merge16(
										pb_q[req.reg_offset[0]], req.write_data,
										req.byte_enable);
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_CMD: begin
					// status acknowledge touches no voice
					if (bank_b_q && cmd_code == CMD_B_ACK) begin
						status_q <= ack_status;
						if (ack_status == 8'd0) begin
							irq_q <= 1'b0;
						end
						state_q <= S_RESP;
					end else begin
						if (bank_b_q && cmd_code == CMD_B_GETF) begin
							pb_q[0] <= '0;
						end
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					rec_q    <= exec_rec;
					delta_q  <= vr_rdata.loop_start - vr_rdata.loop_end;
					looped_q <= 1'b0;
					fr_q     <= exec_fr;
					state_q  <= exec_samp ? S_SAMP : S_WB;
					// position and flag readback into the banks
					if (!op_tick_q && sel && !bank_b_q && cmd_code == CMD_A_GETPOS) begin
						pa_q[1] <= vr_rdata.play[15:0];
						pa_q[2] <= vr_rdata.play[31:16];
					end
					if (!op_tick_q && sel && bank_b_q && cmd_code == CMD_B_GETF) begin
						pb_q[0] <= pb_q[0] | vr_rdata.flags;
					end
				end
				S_SAMP: begin
					rec_q.cur <= sr_rdata;
					state_q   <= S_ITER;
				end
				S_ITER: begin
					if (fr_q < ONE) begin
						state_q <= S_WB;
					end else begin
						fr_q <= fr_q - ONE;
						if (!rec_q.flags[F_REVERSE]) begin
							if (rec_q.play < rec_q.end_addr) begin
								rec_q.play <= rec_q.play + 32'd1;
								if (rec_q.flags[F_LOOP]) begin
									state_q <= S_LOOP;
								end
							end else begin
								rec_q.flags[F_PLAY] <= 1'b0;
							end
						end else begin
							if (rec_q.play > rec_q.end_addr) begin
								rec_q.play <= rec_q.play - 32'd1;
							end else begin
								rec_q.flags[F_PLAY] <= 1'b0;
							end
						end
					end
				end
				S_LOOP: begin
					if (rec_q.play >= rec_q.loop_end) begin
						looped_q <= rec_q.flags[F_INT];
						if (rec_q.trace) begin
							rec_q.play <= rec_q.play + delta_q;
							fr_q       <= fr_q + lsf_ext;
						end else begin
							rec_q.play         <= rec_q.loop_start;
							fr_q               <= lsf_ext;
							rec_q.flags[F_INT] <= 1'b0;
						end
					end
					state_q <= S_ITER;
				end
				S_WB: begin
					// raise the loop interrupt of this voice
					if (looped_q) begin
						status_q <= status_q | (8'd1 << vidx_q);
						irq_q    <= 1'b1;
					end
					if (vidx_q == LAST) begin
						state_q <= S_DR;
					end else begin
						vidx_q  <= vidx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DR: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					// load the result slot once it is free
					if (rsp_load) begin
						out_voice_q <= voice_now;
						out_rd_q    <= rd_q;
						out_irq_q   <= irq_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.voice_out_0 = out_voice_q[0];
	assign rsp.voice_out_1 = out_voice_q[1];
	assign rsp.voice_out_2 = out_voice_q[2];
	assign rsp.voice_out_3 = out_voice_q[3];
	assign rsp.voice_out_4 = out_voice_q[4];
	assign rsp.voice_out_5 = out_voice_q[5];
	assign rsp.voice_out_6 = out_voice_q[6];
	assign rsp.voice_out_7 = out_voice_q[7];
	assign rsp.read_data   = out_rd_q;
	assign rsp.irq_out     = out_irq_q;

	// a pending status bit always keeps the IRQ line up
	a_irq_status: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q != 8'd0) |-> irq_q)
		else $error("status set without IRQ");

	// phase written back is always below one
	a_wb_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB) |-> (fr_q < ONE))
		else $error("phase overflow at write-back");

	// sample fetch only follows a voice read
	a_samp_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SAMP) |-> ($past(state_q) == S_EXEC))
		else $error("sample capture out of order");

endmodule

`default_nettype wire

>>> dv/lpvp_checker.sv
// ----------------------------------------------------------------------------
// lpvp_checker
// Predicts every result item of the voice player from the request items it
// accepts and compares it field by field with the item seen on rsp.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module lpvp_checker import lpvp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	lpvp_req_if   req,
	lpvp_rsp_if   rsp,
	output int    mismatches,
	output int    pending,
	output int    loops_taken
);

	localparam int          FRAC  = 15;
	localparam logic [31:0] UNITY = 32'd1 << FRAC;

	typedef struct {
		logic [15:0] vout [8];
		logic [15:0] rd;
		logic        irq;
	} player_result_t;

	player_result_t due_q [$];

	// register banks and interrupt state
	logic [15:0] bank_a [3];
	logic [15:0] bank_b [2];
	logic [15:0] cmd_word_a, cmd_word_b;
	logic [7:0]  irq_status;
	logic        irq_line;

	// voice state
	logic [15:0] vflags [8];
	logic [31:0] vplay [8];
	logic [15:0] vphase [8];
	logic [31:0] vend [8];
	logic [31:0] vloopstart [8];
	logic [31:0] vloopend [8];
	logic [7:0]  vloopfrac [8];
	logic        vtrace [8];
	logic [15:0] vpitch [8];
	logic [15:0] vcur [8];
	logic [15:0] vprev [8];
	logic [15:0] smem [0:65535];

	function automatic logic [15:0] lane_merge(input logic [15:0] old, input logic [15:0] nu,
			input logic [1:0] be);
		logic [15:0] r;
		r = old;
		if (be[0]) r[7:0] = nu[7:0];
		if (be[1]) r[15:8] = nu[15:8];
		return r;
	endfunction

	// advance one voice by one audio tick
	function automatic void step_voice(input int v);
		logic [31:0] fr;
		logic        looped;
		looped = 1'b0;
		if (!vflags[v][F_PLAY]) return;
		fr = 32'(vphase[v]) + 32'(vpitch[v]);
		if (fr >= UNITY) begin
			vprev[v] = vcur[v];
			vcur[v] = smem[vplay[v][15:0]];
			while (fr >= UNITY) begin
				fr -= UNITY;
				if (!vflags[v][F_REVERSE]) begin
					if (vplay[v] < vend[v]) begin
						vplay[v] = vplay[v] + 32'd1;
						if (vflags[v][F_LOOP] && vplay[v] >= vloopend[v]) begin
							looped = vflags[v][F_INT];
							if (vtrace[v]) begin
								vplay[v] = vloopstart[v] + (vplay[v] - vloopend[v]);
								fr += 32'(vloopfrac[v]) << (FRAC - 8);
							end else begin
								vplay[v] = vloopstart[v];
								fr = 32'(vloopfrac[v]) << (FRAC - 8);
								vflags[v][F_INT] = 1'b0;
							end
						end
					end else begin
						vflags[v][F_PLAY] = 1'b0;
					end
				end else if (vplay[v] > vend[v]) begin
					vplay[v] = vplay[v] - 32'd1;
				end else begin
					vflags[v][F_PLAY] = 1'b0;
				end
			end
			if (looped) begin
				irq_status[v] = 1'b1;
				irq_line = 1'b1;
				loops_taken++;
			end
		end
		vphase[v] = fr[15:0];
	endfunction

	// interpolate between previous and current sample in eighths
	function automatic logic [15:0] voice_level(input int v);
		int last, cur, f, r;
		if (!vflags[v][F_OUTPUT]) return 16'd0;
		last = int'($signed(vprev[v]));
		cur = int'($signed(vcur[v]));
		f = int'(vphase[v][FRAC-1 -: 3]);
		r = last + ((cur - last) * f) / 8;
		return r[15:0];
	endfunction

	function automatic void run_cmd_a();
		for (int v = 0; v < 8; v++) begin
			if (cmd_word_a[v]) begin
				case (cmd_word_a[15:8])
					CMD_A_PLAY: begin
						vplay[v] = {bank_a[2], bank_a[1]};
						vphase[v] = '0;
						vcur[v] = '0;
						vprev[v] = '0;
					end
					CMD_A_LOOP: begin
						vloopstart[v] = {bank_a[1], bank_a[0]};
						vloopfrac[v] = bank_a[2][7:0];
					end
					CMD_A_PITCH: vpitch[v] = bank_a[0];
					CMD_A_GETPOS: begin
						bank_a[1] = vplay[v][15:0];
						bank_a[2] = vplay[v][31:16];
					end
					default: ;
				endcase
			end
		end
	endfunction

	function automatic void run_cmd_b();
		if (cmd_word_b[15:8] == CMD_B_ACK) begin
			irq_status &= bank_b[0][7:0];
			if (irq_status == 8'd0) irq_line = 1'b0;
			return;
		end
		if (cmd_word_b[15:8] == CMD_B_GETF) bank_b[0] = '0;
		for (int v = 0; v < 8; v++) begin
			if (cmd_word_b[v]) begin
				case (cmd_word_b[15:8])
					CMD_B_END:     vend[v] = {bank_b[1], bank_b[0]};
					CMD_B_LOOPEND: vloopend[v] = {bank_b[1], bank_b[0]};
					CMD_B_SETF:    vflags[v] |= bank_b[0];
					CMD_B_CLRF:    vflags[v] &= ~bank_b[0];
					CMD_B_TRACE:   vtrace[v] = bank_b[0][0];
					CMD_B_GETF:    bank_b[0] |= vflags[v];
					default: ;
				endcase
			end
		end
	endfunction

	// apply one request item and return the result it causes
	function automatic player_result_t apply_item(input logic [2:0] mode, input logic [1:0] off,
			input logic [15:0] data, input logic [1:0] be, input logic [15:0] addr,
			input logic [15:0] sample);
		player_result_t r;
		r.rd = '0;
		case (mode)
			MODE_TICK: for (int v = 0; v < 8; v++) step_voice(v);
			MODE_WR_A: begin
				if (off != OFF_CMD) begin
					bank_a[off] = lane_merge(bank_a[off], data, be);
				end else begin
					cmd_word_a = lane_merge(cmd_word_a, data, be);
					if (be[1]) run_cmd_a();
				end
			end
			MODE_WR_B: begin
				if (off < OFF_STATUS) begin
					bank_b[off] = lane_merge(bank_b[off], data, be);
				end else if (off == OFF_CMD) begin
					cmd_word_b = lane_merge(cmd_word_b, data, be);
					if (be[1]) run_cmd_b();
				end
			end
			MODE_RD_A: r.rd = (off == OFF_CMD) ? cmd_word_a : bank_a[off];
			MODE_RD_B: begin
				if (off < OFF_STATUS) r.rd = bank_b[off];
				else if (off == OFF_STATUS) r.rd = {8'd0, irq_status};
				else r.rd = cmd_word_b;
			end
			MODE_LOAD: smem[addr] = sample;
			default: ;
		endcase
		for (int v = 0; v < 8; v++) r.vout[v] = voice_level(v);
		r.irq = irq_line;
		return r;
	endfunction

	function automatic void clear_state();
		for (int k = 0; k < 3; k++) bank_a[k] = '0;
		for (int k = 0; k < 2; k++) bank_b[k] = '0;
		cmd_word_a = '0;
		cmd_word_b = '0;
		irq_status = '0;
		irq_line = 1'b0;
		for (int v = 0; v < 8; v++) begin
			vflags[v] = '0; vplay[v] = '0; vphase[v] = '0; vend[v] = '0;
			vloopstart[v] = '0; vloopend[v] = '0; vloopfrac[v] = '0; vtrace[v] = 1'b0;
			vpitch[v] = '0; vcur[v] = '0; vprev[v] = '0;
		end
	endfunction

	initial begin
		mismatches = 0;
		loops_taken = 0;
		clear_state();
		for (int k = 0; k < 65536; k++) smem[k] = '0;
	end

	assign pending = due_q.size();

	// check results first, then predict the item accepted at this edge
	always @(posedge clk or negedge arst_n) begin
		player_result_t want;
		logic [15:0]    got [8];
		logic           bad;
		if (!arst_n) begin
			clear_state();
			due_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.voice_out_0, rsp.voice_out_1, rsp.voice_out_2, rsp.voice_out_3,
					rsp.voice_out_4, rsp.voice_out_5, rsp.voice_out_6, rsp.voice_out_7};
				if (due_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("%0t: result item with none expected", $realtime);
				end else begin
					want = due_q.pop_front();
					bad = (want.rd !== rsp.read_data) || (want.irq !== rsp.irq_out);
					for (int v = 0; v < 8; v++) if (want.vout[v] !== got[v]) bad = 1'b1;
					if (bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch: read_data exp %h got %h, irq exp %b got %b",
								$realtime, want.rd, rsp.read_data, want.irq, rsp.irq_out);
							for (int v = 0; v < 8; v++)
								if (want.vout[v] !== got[v])
									$display("  voice %0d exp %h got %h", v, want.vout[v], got[v]);
						end
					end
				end
			end
			if (req.valid && req.ready)
				due_q.push_back(apply_item(req.mode, req.reg_offset, req.write_data,
					req.byte_enable, req.mem_address, req.mem_sample));
		end
	end

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives bus accesses, sample loads and audio ticks into the voice player
// with random gaps and rsp stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;
	import lpvp_pkg::*;

	localparam int          ITEM_TARGET = 1250;
	localparam int          IDLE_LIMIT  = 3000;
	localparam logic [1:0]  OFF_P0 = 2'd0;
	localparam logic [1:0]  OFF_P1 = 2'd1;
	localparam logic [1:0]  OFF_P2 = 2'd2;
	localparam logic [2:0]  MODE_SPARE6 = 3'd6;
	localparam logic [2:0]  MODE_SPARE7 = 3'd7;
	localparam logic [7:0]  CMD_A_LOOPLEN = 8'h43;
	localparam logic [7:0]  CMD_A_XFADE   = 8'h45;
	localparam logic [7:0]  CMD_NONE      = 8'hff;
	localparam logic [15:0] FLAG_SOUND = 16'h0003;
	localparam logic [1:0]  BE_BOTH = 2'b11;

	logic clk;
	logic arst_n;
	logic no_idle;
	int   items_sent, ticks_sent, idle_cycles;
	int   mismatches, pending, loops_taken;

	lpvp_req_if req_ch();
	lpvp_rsp_if rsp_ch();

	looping_pcm_voice_player_core dut (.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch));

	lpvp_checker scoreboard (.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.mismatches(mismatches), .pending(pending), .loops_taken(loops_taken));

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 14);
	endfunction

	// present one item after a random gap, hold it until accepted, then drop valid
	task automatic send_item(input logic [2:0] mode, input logic [1:0] off,
			input logic [15:0] data, input logic [1:0] be, input logic [15:0] addr,
			input logic [15:0] sample);
		int gap;
		gap = draw_gap();
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.mode = mode;
		req_ch.reg_offset = off;
		req_ch.write_data = data;
		req_ch.byte_enable = be;
		req_ch.mem_address = addr;
		req_ch.mem_sample = sample;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		items_sent++;
		if (mode == MODE_TICK) ticks_sent++;
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	task automatic wr_a(input logic [1:0] off, input logic [15:0] data);
		send_item(MODE_WR_A, off, data, BE_BOTH, 16'($urandom), 16'($urandom));
	endtask

	task automatic wr_b(input logic [1:0] off, input logic [15:0] data);
		send_item(MODE_WR_B, off, data, BE_BOTH, 16'($urandom), 16'($urandom));
	endtask

	task automatic cmd_a(input logic [7:0] code, input logic [7:0] mask);
		wr_a(OFF_CMD, {code, mask});
	endtask

	task automatic cmd_b(input logic [7:0] code, input logic [7:0] mask);
		wr_b(OFF_CMD, {code, mask});
	endtask

	task automatic tick();
		send_item(MODE_TICK, 2'($urandom), 16'($urandom), 2'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	// program a full voice setup; addresses stay inside the preloaded window
	task automatic arm_voice(input logic [7:0] mask, input logic [15:0] play,
			input logic [15:0] stop, input logic [15:0] lstart, input logic [15:0] lfrac,
			input logic [15:0] lend, input logic [15:0] pitch, input logic [15:0] flags,
			input logic [15:0] trace);
		wr_a(OFF_P1, play);
		wr_a(OFF_P2, 16'd0);
		cmd_a(CMD_A_PLAY, mask);
		wr_a(OFF_P0, lstart);
		wr_a(OFF_P1, 16'd0);
		wr_a(OFF_P2, lfrac);
		cmd_a(CMD_A_LOOP, mask);
		wr_a(OFF_P0, pitch);
		cmd_a(CMD_A_PITCH, mask);
		wr_b(OFF_P0, stop);
		wr_b(OFF_P1, 16'd0);
		cmd_b(CMD_B_END, mask);
		wr_b(OFF_P0, lend);
		cmd_b(CMD_B_LOOPEND, mask);
		wr_b(OFF_P0, trace);
		cmd_b(CMD_B_TRACE, mask);
		wr_b(OFF_P0, 16'hffff);
		cmd_b(CMD_B_CLRF, mask);
		wr_b(OFF_P0, flags);
		cmd_b(CMD_B_SETF, mask);
	endtask

	task automatic arm_random();
		logic [15:0] flags;
		flags = 16'($urandom);
		if ($urandom_range(0, 9) < 8) flags |= FLAG_SOUND;
		arm_voice(8'($urandom), 16'($urandom_range(0, 47)), 16'($urandom_range(0, 47)),
			16'($urandom_range(0, 47)), 16'($urandom), 16'($urandom_range(0, 47)),
			16'($urandom), flags, 16'($urandom));
	endtask

	// stall the result side at random
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			int stall;
			stall = draw_gap();
			repeat (stall) begin
				@(negedge clk);
				rsp_ch.ready = 1'b0;
			end
			@(negedge clk);
			rsp_ch.ready = 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
		end
	end

	// count cycles in which neither channel moves an item
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int pick;
		items_sent = 0;
		ticks_sent = 0;
		idle_cycles = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_TICK;
		req_ch.reg_offset = '0;
		req_ch.write_data = '0;
		req_ch.byte_enable = '0;
		req_ch.mem_address = '0;
		req_ch.mem_sample = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill the sample window that voices may play from
		no_idle = 1'b1;
		send_item(MODE_LOAD, OFF_P0, '0, '0, 16'd0, 16'h8000);
		send_item(MODE_LOAD, OFF_P0, '0, '0, 16'd1, 16'h7fff);
		for (int a = 2; a < 128; a++)
			send_item(MODE_LOAD, OFF_P0, '0, '0, 16'(a), 16'($urandom));
		no_idle = 1'b0;

		// directed: reads, odd modes, partial writes, unused codes
		send_item(MODE_RD_A, OFF_CMD, '0, '0, '0, '0);
		send_item(MODE_RD_B, OFF_STATUS, '0, '0, '0, '0);
		send_item(MODE_SPARE6, OFF_P0, 16'hffff, 2'b11, 16'hffff, 16'hffff);
		send_item(MODE_SPARE7, OFF_P1, 16'hffff, 2'b11, 16'hffff, 16'hffff);
		send_item(MODE_WR_A, OFF_P0, 16'hffff, 2'b00, '0, '0);
		send_item(MODE_WR_A, OFF_P0, 16'h1234, 2'b01, '0, '0);
		send_item(MODE_WR_A, OFF_P0, 16'hab00, 2'b10, '0, '0);
		send_item(MODE_RD_A, OFF_P0, '0, '0, '0, '0);
		send_item(MODE_WR_B, OFF_STATUS, 16'hffff, 2'b11, '0, '0);
		send_item(MODE_WR_A, OFF_CMD, {CMD_A_LOOPLEN, 8'hff}, 2'b01, '0, '0);
		send_item(MODE_WR_A, OFF_CMD, {CMD_A_LOOPLEN, 8'h00}, 2'b10, '0, '0);
		cmd_a(CMD_A_XFADE, 8'hff);
		cmd_b(CMD_NONE, 8'hff);

		// forward skip loop with interrupt, full pitch, then acknowledge
		arm_voice(8'h01, 16'd2, 16'd40, 16'd4, 16'h0080, 16'd6, 16'hffff, 16'h000f, 16'd0);
		repeat (4) tick();
		cmd_a(CMD_A_GETPOS, 8'h01);
		cmd_b(CMD_B_GETF, 8'hff);
		send_item(MODE_RD_B, OFF_STATUS, '0, '0, '0, '0);
		wr_b(OFF_P0, 16'h0000);
		cmd_b(CMD_B_ACK, 8'h00);
		// reverse playback down to the end address, and a trace loop
		arm_voice(8'h80, 16'd30, 16'd28, '0, '0, '0, 16'h8000, 16'h0013, 16'd0);
		arm_voice(8'h40, 16'd0, 16'd47, 16'd10, 16'h00ff, 16'd3, 16'hc000, 16'h000f, 16'd1);
		repeat (6) tick();

		// hold until the block has drained, then random traffic
		wait (pending == 0);
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 19) == 0) no_idle = ~no_idle;
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				repeat ($urandom_range(1, 6)) tick();
			end else if (pick < 45) begin
				arm_random();
			end else if (pick < 52) begin
				wr_b(OFF_P0, 16'($urandom));
				cmd_b(CMD_B_ACK, 8'($urandom));
			end else if (pick < 62) begin
				send_item($urandom_range(0, 1) ? MODE_RD_A : MODE_RD_B, 2'($urandom),
					16'($urandom), 2'($urandom), 16'($urandom), 16'($urandom));
			end else if (pick < 68) begin
				cmd_a(CMD_A_GETPOS, 8'($urandom));
			end else if (pick < 74) begin
				cmd_b(CMD_B_GETF, 8'($urandom));
			end else if (pick < 82) begin
				wr_b(OFF_P0, 16'($urandom));
				cmd_b($urandom_range(0, 1) ? CMD_B_SETF : CMD_B_CLRF, 8'($urandom));
			end else if (pick < 85) begin
				wr_b(OFF_P0, 16'($urandom));
				cmd_b(CMD_B_TRACE, 8'($urandom));
			end else if (pick < 88) begin
				wr_a(OFF_P0, 16'($urandom));
				cmd_a(CMD_A_PITCH, 8'($urandom));
			end else if (pick < 93) begin
				// parameter noise and commands that only store the word
				send_item($urandom_range(0, 1) ? MODE_WR_A : MODE_WR_B,
					2'($urandom_range(0, 2)), 16'($urandom), 2'($urandom), 16'($urandom),
					16'($urandom));
				send_item(MODE_WR_A, OFF_CMD, 16'($urandom), 2'b01, 16'($urandom),
					16'($urandom));
				cmd_a($urandom_range(0, 1) ? CMD_A_XFADE : CMD_A_LOOPLEN, 8'($urandom));
			end else if (pick < 98) begin
				send_item(MODE_LOAD, 2'($urandom), 16'($urandom), 2'($urandom), 16'($urandom),
					16'($urandom));
			end else begin
				send_item($urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7, 2'($urandom),
					16'($urandom), 2'($urandom), 16'($urandom), 16'($urandom));
			end
		end
		@(negedge clk);
		req_ch.valid = 1'b0;

		wait (pending == 0);
		repeat (200) @(posedge clk);
		$display("Sent %0d items (%0d audio ticks); %0d interrupting loops were predicted.",
			items_sent, ticks_sent, loops_taken);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d result items did not match", mismatches);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
sv/lpvp_pkg.sv
sv/lpvp_req_if.sv
sv/lpvp_rsp_if.sv
sv/lpvp_sample_ram.sv
sv/lpvp_voice_ram.sv
sv/lpvp_interp.sv
sv/looping_pcm_voice_player_core.sv
dv/lpvp_checker.sv
dv/testbench.sv
